@@ rtl/oeg_pkg.sv @@
package oeg_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int ROW_W = 64;
  localparam int NODE_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIST_W = 8;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SWAP   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_PAIRWISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODES    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNREACH  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_WR_A,
    ST_WR_B,
    ST_WR_C,
    ST_Q_CHECK,
    ST_Q_RD,
    ST_Q_ACC,
    ST_DONE
  } state_t;

endpackage

@@ rtl/oeg_ram.sv @@
module oeg_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/owned_edge_graph_hop_distance.sv @@
// Edit commands step through RD_A, RD_B, WR_A and WR_B before out_valid, with
// WR_C added for an applied swap; a failed precondition ends after WR_A and a
// node out of range after RD_A. Queries search level by level and read one
// adjacency row per frontier node through the one adjacency read port.
// One command at a time; busy drops the cycle after the result beat, which the
// receiver cannot stall. Sync active-low reset clears memories, busy meanwhile.
module owned_edge_graph_hop_distance #(
  parameter int MAX_NODES = oeg_pkg::MAX_NODES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_cmd,
  input  logic [oeg_pkg::NODE_W-1:0]          in_node_a,
  input  logic [oeg_pkg::NODE_W-1:0]          in_node_b,
  input  logic [oeg_pkg::NODE_W-1:0]          in_node_c,
  output logic                                out_valid,
  output logic [oeg_pkg::DIST_W-1:0]          out_distance,
  output logic                                out_status,
  input  logic                                cfg_we,
  input  logic [oeg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [oeg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int ROWS = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int AW = oeg_pkg::NODE_W;
  localparam int W = oeg_pkg::ROW_W;

  // config registers
  logic       pw_r;
  logic [6:0] nodes_r;
  logic [7:0] unr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_r <= 1'b0;
      nodes_r <= 7'd64;
      unr_r <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_index)
        oeg_pkg::REG_PAIRWISE: pw_r <= cfg_data[0];
        oeg_pkg::REG_NODES:    nodes_r <= cfg_data[6:0];
        oeg_pkg::REG_UNREACH:  unr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective node count and live mask
  logic [6:0]   live_n;
  logic [W-1:0] live_mask;
  always_comb begin
    live_n = (nodes_r > 7'(ROWS)) ? 7'(ROWS) : nodes_r;
    for (int i = 0; i < W; i++) begin
      live_mask[i] = (7'(i) < live_n);
    end
  end

  // memories
  logic          adj_we, own_we;
  logic [AW-1:0] adj_wa, own_wa, adj_ra, own_ra;
  logic [W-1:0]  adj_wd, own_wd, adj_rd, own_rd;

  oeg_ram #(.WIDTH(W), .DEPTH(64)) u_adj (
    .clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd),
    .raddr(adj_ra), .rdata(adj_rd)
  );
  oeg_ram #(.WIDTH(W), .DEPTH(64)) u_own (
    .clk(clk), .we(own_we), .waddr(own_wa), .wdata(own_wd),
    .raddr(own_ra), .rdata(own_rd)
  );

  oeg_pkg::state_t st_r, st_nxt;
  logic          clr_r;
  logic [AW:0]   clr_cnt_r;
  logic [1:0]    cmd_r;
  logic [AW-1:0] a_r, b_r, c_r;
  logic [W-1:0]  adj_a_r, own_a_r, adj_a_nxt, own_a_nxt;
  logic [W-1:0]  vis_r, fr_r, nx_r, vis_nxt, fr_nxt, nx_nxt;
  logic [AW-1:0] scan_r, scan_nxt;
  logic [7:0]    hops_r, hops_nxt;
  logic [7:0]    dist_r, dist_nxt;
  logic          bad_r, bad_nxt;
  logic          ok_r, ok_nxt, rm_adj_r, rm_adj_nxt;

  // range checks on the held command
  logic in_rng, c_rng;
  assign in_rng = ({1'b0, a_r} < live_n) && ({1'b0, b_r} < live_n);
  assign c_rng  = ({1'b0, c_r} < live_n);

  // lowest frontier node at or after the scan pointer
  logic [W-1:0]  fr_rem;
  logic          fr_any;
  logic [AW-1:0] fr_idx;
  always_comb begin
    fr_rem = fr_r & ~((W'(1) << scan_r) - W'(1));
    fr_any = |fr_rem;
    fr_idx = '0;
    for (int i = W - 1; i >= 0; i--) begin
      if (fr_rem[i]) fr_idx = AW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= oeg_pkg::ST_IDLE;
      clr_r <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == (AW+1)'(63)) clr_r <= 1'b0;
      end
    end
  end

  // hold command and working values
  always_ff @(posedge clk) begin
    if (st_r == oeg_pkg::ST_IDLE && start && !busy) begin
      cmd_r <= in_cmd;
      a_r <= in_node_a;
      b_r <= in_node_b;
      c_r <= in_node_c;
    end
    adj_a_r <= adj_a_nxt;
    own_a_r <= own_a_nxt;
    vis_r <= vis_nxt;
    fr_r <= fr_nxt;
    nx_r <= nx_nxt;
    scan_r <= scan_nxt;
    hops_r <= hops_nxt;
    dist_r <= dist_nxt;
    bad_r <= bad_nxt;
    ok_r <= ok_nxt;
    rm_adj_r <= rm_adj_nxt;
  end

  assign busy = clr_r || (st_r != oeg_pkg::ST_IDLE);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      oeg_pkg::ST_IDLE:
        if (start && !busy) st_nxt = oeg_pkg::ST_RD_A;
      oeg_pkg::ST_RD_A: begin
        if (!in_rng) st_nxt = oeg_pkg::ST_DONE;
        else if (cmd_r == oeg_pkg::CMD_QUERY) st_nxt = oeg_pkg::ST_Q_CHECK;
        else st_nxt = oeg_pkg::ST_RD_B;
      end
      oeg_pkg::ST_RD_B: st_nxt = oeg_pkg::ST_WR_A;
      oeg_pkg::ST_WR_A: st_nxt = ok_r ? oeg_pkg::ST_WR_B : oeg_pkg::ST_DONE;
      oeg_pkg::ST_WR_B:
        st_nxt = (cmd_r == oeg_pkg::CMD_SWAP) ? oeg_pkg::ST_WR_C : oeg_pkg::ST_DONE;
      oeg_pkg::ST_WR_C: st_nxt = oeg_pkg::ST_DONE;
      oeg_pkg::ST_Q_CHECK: begin
        if (fr_r[b_r]) st_nxt = oeg_pkg::ST_DONE;
        else st_nxt = oeg_pkg::ST_Q_RD;
      end
      oeg_pkg::ST_Q_RD: begin
        if (fr_any) st_nxt = oeg_pkg::ST_Q_ACC;
        else if ((nx_r & live_mask & ~vis_r) == '0) st_nxt = oeg_pkg::ST_DONE;
        else st_nxt = oeg_pkg::ST_Q_CHECK;
      end
      oeg_pkg::ST_Q_ACC: st_nxt = oeg_pkg::ST_Q_RD;
      oeg_pkg::ST_DONE: st_nxt = oeg_pkg::ST_IDLE;
      default: st_nxt = oeg_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    logic [W-1:0] ba, bb, bc, nxm;
    ba = W'(1) << a_r;
    bb = W'(1) << b_r;
    bc = W'(1) << c_r;
    nxm = nx_r & live_mask & ~vis_r;
    adj_a_nxt = adj_a_r;
    own_a_nxt = own_a_r;
    vis_nxt = vis_r;
    fr_nxt = fr_r;
    nx_nxt = nx_r;
    scan_nxt = scan_r;
    hops_nxt = hops_r;
    dist_nxt = dist_r;
    bad_nxt = bad_r;
    ok_nxt = ok_r;
    rm_adj_nxt = rm_adj_r;
    adj_we = 1'b0;
    own_we = 1'b0;
    adj_wa = a_r;
    own_wa = a_r;
    adj_wd = adj_rd;
    own_wd = own_rd;
    adj_ra = a_r;
    own_ra = a_r;
    if (clr_r) begin
      adj_we = 1'b1;
      own_we = 1'b1;
      adj_wa = clr_cnt_r[AW-1:0];
      own_wa = clr_cnt_r[AW-1:0];
      adj_wd = '0;
      own_wd = '0;
    end
    case (st_r)
      oeg_pkg::ST_IDLE: begin
        adj_ra = in_node_a;
        own_ra = in_node_a;
        dist_nxt = '0;
        bad_nxt = 1'b1;
      end
      oeg_pkg::ST_RD_A: begin
        // row a available; issue row b
        adj_a_nxt = adj_rd;
        own_a_nxt = own_rd;
        adj_ra = b_r;
        own_ra = b_r;
        vis_nxt = ba;
        fr_nxt = ba;
        nx_nxt = '0;
        scan_nxt = '0;
        hops_nxt = '0;
        if (in_rng && cmd_r == oeg_pkg::CMD_QUERY) bad_nxt = 1'b0;
      end
      oeg_pkg::ST_RD_B: begin
        // decide and write row a
        adj_ra = c_r;
        ok_nxt = 1'b0;
        case (cmd_r)
          oeg_pkg::CMD_ADD: ok_nxt = (a_r != b_r);
          oeg_pkg::CMD_REMOVE: ok_nxt = (a_r != b_r) && own_a_r[b_r];
          oeg_pkg::CMD_SWAP:
            ok_nxt = !pw_r && c_rng && (a_r != b_r) && (a_r != c_r) &&
                     own_a_r[b_r] && !adj_a_r[c_r];
          default: ok_nxt = 1'b0;
        endcase
        rm_adj_nxt = !own_rd[a_r] || pw_r;
        // keep row b for the next write
        adj_a_nxt = adj_rd;
        own_a_nxt = own_rd;
        if (ok_nxt) begin
          bad_nxt = 1'b0;
          adj_we = 1'b1;
          own_we = 1'b1;
          case (cmd_r)
            oeg_pkg::CMD_ADD: begin
              adj_wd = adj_a_r | bb;
              own_wd = own_a_r | bb;
            end
            oeg_pkg::CMD_REMOVE: begin
              own_wd = own_a_r & ~bb;
              adj_wd = rm_adj_nxt ? (adj_a_r & ~bb) : adj_a_r;
            end
            default: begin
              own_wd = (own_a_r & ~bb) | bc;
              adj_wd = (adj_a_r & ~bb) | bc;
            end
          endcase
        end
      end
      oeg_pkg::ST_WR_A: begin
        // row b write (adj_a_r/own_a_r hold row b now)
        adj_wa = b_r;
        own_wa = b_r;
        adj_wd = adj_a_r;
        own_wd = own_a_r;
        if (ok_r) begin
          adj_we = 1'b1;
          own_we = 1'b1;
          case (cmd_r)
            oeg_pkg::CMD_ADD: begin
              adj_wd = adj_a_r | ba;
              own_wd = pw_r ? (own_a_r | ba) : own_a_r;
            end
            oeg_pkg::CMD_REMOVE: begin
              adj_wd = rm_adj_r ? (adj_a_r & ~ba) : adj_a_r;
              own_wd = pw_r ? (own_a_r & ~ba) : own_a_r;
            end
            default: begin
              adj_wd = adj_a_r & ~ba;
              own_we = 1'b0;
            end
          endcase
        end
        // row c read was issued in RD_B; capture it
        adj_a_nxt = adj_rd;
      end
      oeg_pkg::ST_WR_B: begin
        // swap: set a in row c; when c equals b, bit a of that row was
        // already clear, so the stale copy still gives the right row
        if (cmd_r == oeg_pkg::CMD_SWAP) begin
          adj_we = 1'b1;
          adj_wa = c_r;
          adj_wd = adj_a_r | ba;
        end
      end
      oeg_pkg::ST_WR_C: ;
      oeg_pkg::ST_Q_CHECK: begin
        if (fr_r[b_r]) dist_nxt = hops_r;
        scan_nxt = '0;
        nx_nxt = '0;
      end
      oeg_pkg::ST_Q_RD: begin
        adj_ra = fr_idx;
        if (fr_any) begin
          scan_nxt = fr_idx;
        end else if (nxm == '0) begin
          dist_nxt = unr_r;
        end else begin
          fr_nxt = nxm;
          vis_nxt = vis_r | nxm;
          hops_nxt = hops_r + 8'd1;
        end
      end
      oeg_pkg::ST_Q_ACC: begin
        nx_nxt = nx_r | adj_rd;
        if (scan_r == AW'(W - 1)) fr_nxt = fr_r & ~(W'(1) << scan_r);
        else scan_nxt = scan_r + 1'b1;
        if (scan_r == AW'(W - 1)) scan_nxt = scan_r;
      end
      default: ;
    endcase
  end

  // result beat
  always_comb begin
    out_valid = (st_r == oeg_pkg::ST_DONE);
    out_distance = dist_r;
    out_status = bad_r;
  end

endmodule
